>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLKRST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

>>> rtl/hkc_pkg.sv
// ----------------------------------------------------------------------------
// hkc_pkg
// Constants, tables and types of the halfwidth kana converter.
// ----------------------------------------------------------------------------
package hkc_pkg;

  localparam int unsigned UnitW   = 16;
  localparam int unsigned KataLen = 92;
  localparam int unsigned KataIdxW = $clog2(KataLen);

  localparam logic [UnitW-1:0] HiraFirst  = 16'h3041;
  localparam logic [UnitW-1:0] HiraLast   = 16'h3096;
  localparam logic [UnitW-1:0] HiraShift  = 16'h0060;
  localparam logic [UnitW-1:0] KataFirst  = 16'h30A1;
  localparam logic [UnitW-1:0] KataLast   = 16'h30FC;
  localparam logic [UnitW-1:0] IdeoComma  = 16'h3001;
  localparam logic [UnitW-1:0] IdeoStop   = 16'h3002;
  localparam logic [UnitW-1:0] CornerOpen = 16'h300C;
  localparam logic [UnitW-1:0] CornerShut = 16'h300D;
  localparam logic [UnitW-1:0] HwComma    = 16'hFF64;
  localparam logic [UnitW-1:0] HwStop     = 16'hFF61;
  localparam logic [UnitW-1:0] HwOpen     = 16'hFF62;
  localparam logic [UnitW-1:0] HwShut     = 16'hFF63;
  localparam logic [UnitW-1:0] FwAsciiLo  = 16'hFF01;
  localparam logic [UnitW-1:0] FwAsciiHi  = 16'hFF5E;
  localparam logic [UnitW-1:0] FwOffset   = 16'hFEE0;
  localparam logic [UnitW-1:0] IdeoSpace  = 16'h3000;
  localparam logic [UnitW-1:0] AsciiSpace = 16'h0020;
  localparam logic [UnitW-1:0] MarkVoiced = 16'hFF9E;
  localparam logic [UnitW-1:0] MarkSemi   = 16'hFF9F;
  localparam logic [7:0]       HwPage     = 8'hFF;

  // Low byte: halfwidth unit minus 0xFF00 (zero: no mapping); bit 8: voiced;
  // bit 9: semi-voiced.
  localparam logic [9:0] KATA_MAP [KataLen] = '{
    10'h067, 10'h071, 10'h068, 10'h072, 10'h069, 10'h073, 10'h06A, 10'h074,
    10'h06B, 10'h075,
    10'h076, 10'h176, 10'h077, 10'h177, 10'h078, 10'h178,
    10'h079, 10'h179, 10'h07A, 10'h17A,
    10'h07B, 10'h17B, 10'h07C, 10'h17C, 10'h07D, 10'h17D,
    10'h07E, 10'h17E, 10'h07F, 10'h17F,
    10'h080, 10'h180, 10'h081, 10'h181, 10'h06F, 10'h082, 10'h182,
    10'h083, 10'h183, 10'h084, 10'h184,
    10'h085, 10'h086, 10'h087, 10'h088, 10'h089,
    10'h08A, 10'h18A, 10'h28A, 10'h08B, 10'h18B, 10'h28B,
    10'h08C, 10'h18C, 10'h28C, 10'h08D, 10'h18D, 10'h28D,
    10'h08E, 10'h18E, 10'h28E,
    10'h08F, 10'h090, 10'h091, 10'h092, 10'h093,
    10'h06C, 10'h094, 10'h06D, 10'h095, 10'h06E, 10'h096,
    10'h097, 10'h098, 10'h099, 10'h09A, 10'h09B,
    10'h000, 10'h09C, 10'h000, 10'h000, 10'h066, 10'h09D, 10'h173, 10'h000,
    10'h000,
    10'h000, 10'h000, 10'h000, 10'h000, 10'h065, 10'h070
  };

  // Converted item between the lookup stage and the output stage.
  typedef struct packed {
    logic [UnitW-1:0] first;
    logic             two;
    logic             semi;
    logic             eot;
  } conv_t;

endpackage

>>> rtl/hkc_expand.sv
// ----------------------------------------------------------------------------
// hkc_expand
// Output stage: presents one or two units per converted item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkc_expand (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  hkc_pkg::conv_t              conv_i,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [hkc_pkg::UnitW-1:0]   m_axis_tdata,  // [15:0] out_unit
  output logic                        m_axis_tlast,  // last_of_run
  output logic                        m_axis_tuser   // [0] end_of_text_res
);
  import hkc_pkg::*;

  logic             valid_q, valid_d;
  logic             pend_q, pend_d;
  logic             semi_q, semi_d;
  logic             peot_q, peot_d;
  logic [UnitW-1:0] unit_q, unit_d;
  logic             last_q, last_d;
  logic             eot_q, eot_d;
  logic             take_out;
  logic             load;

  assign take_out   = valid_q & m_axis_tready;
  assign in_ready_o = ~valid_q | (m_axis_tready & ~pend_q);
  assign load       = in_valid_i & in_ready_o;

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    semi_d  = semi_q;
    peot_d  = peot_q;
    unit_d  = unit_q;
    last_d  = last_q;
    eot_d   = eot_q;
    if (take_out && pend_q) begin
      // emit the mark after the base kana
      unit_d = semi_q ? MarkSemi : MarkVoiced;
      last_d = 1'b1;
      eot_d  = peot_q;
      pend_d = 1'b0;
    end else if (load) begin
      valid_d = 1'b1;
      unit_d  = conv_i.first;
      last_d  = ~conv_i.two;
      eot_d   = conv_i.eot & ~conv_i.two;
      pend_d  = conv_i.two;
      semi_d  = conv_i.semi;
      peot_d  = conv_i.eot;
    end else if (take_out) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    semi_q <= semi_d;
    peot_q <= peot_d;
    unit_q <= unit_d;
    last_q <= last_d;
    eot_q  <= eot_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = unit_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = eot_q;

  `ASSERT_CLK(a_pend_has_valid, clk_i, !pend_q || valid_q)
  `ASSERT_CLKRST(a_mark_follows, clk_i, rst_ni,
                 (valid_q && m_axis_tready && pend_q) |=> (valid_q && last_q))
  `ASSERT_CLKRST(a_eot_on_last, clk_i, rst_ni, valid_q |-> (!eot_q || last_q))
  `ASSERT_CLKRST(a_no_load_pending, clk_i, rst_ni, pend_q |-> !in_ready_o)

endmodule

>>> rtl/halfwidth_kana_converter_unit.sv
// ----------------------------------------------------------------------------
// halfwidth_kana_converter_unit
// Streaming UTF-16 fullwidth to halfwidth kana converter.
// ----------------------------------------------------------------------------
// Takes one code unit per cycle while the output is not stalled and no mark is
// pending, and passes it through three register stages: hiragana shift, table
// lookup, output register. Voiced and semi-voiced kana give two output units
// (base kana, then the mark); the output register holds the input side while
// the mark is pending, so no new item is taken before that mark is out.

module halfwidth_kana_converter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [hkc_pkg::UnitW-1:0]   s_axis_tdata,  // [15:0] code_unit
  input  logic                        s_axis_tlast,  // end_of_text
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [hkc_pkg::UnitW-1:0]   m_axis_tdata,  // [15:0] out_unit
  output logic                        m_axis_tlast,  // last_of_run
  output logic                        m_axis_tuser   // [0] end_of_text_res
);
  import hkc_pkg::*;

  // stage 1: hiragana shift
  logic             v1_q;
  logic [UnitW-1:0] u1_q, u1_d;
  logic             eot1_q;
  logic             rdy1;

  // stage 2: lookup
  logic             v2_q;
  conv_t            c2_q, c2_d;
  logic             rdy2;
  logic             rdy3;

  logic [UnitW-1:0] kofs;
  logic [9:0]       kent;
  logic             kata_hit;

  assign rdy2          = ~v2_q | rdy3;
  assign rdy1          = ~v1_q | rdy2;
  assign s_axis_tready = rdy1;

  always_comb begin
    u1_d = s_axis_tdata;
    if (s_axis_tdata >= HiraFirst && s_axis_tdata <= HiraLast) begin
      u1_d = s_axis_tdata + HiraShift;
    end
  end

  always_comb begin
    kofs     = u1_q - KataFirst;
    kent     = KATA_MAP[kofs[KataIdxW-1:0]];
    kata_hit = (u1_q >= KataFirst) && (u1_q <= KataLast) && (kent[7:0] != 8'h00);
    c2_d.two  = 1'b0;
    c2_d.semi = 1'b0;
    c2_d.eot  = eot1_q;
    if (kata_hit) begin
      c2_d.first = {HwPage, kent[7:0]};
      c2_d.two   = kent[8] | kent[9];
      c2_d.semi  = kent[9];
    end else if (u1_q == IdeoComma) begin
      c2_d.first = HwComma;
    end else if (u1_q == IdeoStop) begin
      c2_d.first = HwStop;
    end else if (u1_q == CornerOpen) begin
      c2_d.first = HwOpen;
    end else if (u1_q == CornerShut) begin
      c2_d.first = HwShut;
    end else if (u1_q >= FwAsciiLo && u1_q <= FwAsciiHi) begin
      c2_d.first = u1_q - FwOffset;
    end else if (u1_q == IdeoSpace) begin
      c2_d.first = AsciiSpace;
    end else begin
      c2_d.first = u1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      u1_q   <= u1_d;
      eot1_q <= s_axis_tlast;
    end
    if (rdy2) begin
      c2_q <= c2_d;
    end
  end

  hkc_expand u_expand (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (v2_q),
    .in_ready_o    (rdy3),
    .conv_i        (c2_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
